// ----- src/one_compartment_infusion_step_top_defines.svh -----
// Assertion macros shared by the one-compartment infusion step RTL.
`ifndef ONE_COMPARTMENT_INFUSION_STEP_TOP_DEFINES_SVH
`define ONE_COMPARTMENT_INFUSION_STEP_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define OCIS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define OCIS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define OCIS_ASSERT(lbl, prop, msg)
`define OCIS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- src/ocis_pkg.sv -----
// Types, constants and tables of the one-compartment infusion step.
`default_nettype none
package ocis_pkg;
	localparam logic [31:0] EXP_NEG_ONE = 32'd1580030169;
	localparam logic [31:0] AMOUNT_MAX = 32'hFFFF_FFFF;
	localparam logic [5:0] X_STEPS = 6'd37;
	localparam logic [5:0] Q_STEPS = 6'd32;
	localparam logic [3:0] TERM_FIRST = 4'd2;
	localparam logic [3:0] TERM_LAST = 4'd13;
	localparam logic [33:0] ONE_Q32 = 34'h1_0000_0000;

	typedef struct packed {
		logic start;
		logic [31:0] divisor;
		logic [31:0] hi;
		logic [36:0] lo;
		logic [5:0] steps;
	} div_req_t;

	typedef enum logic [4:0] {
		S_IDLE, S_ZC_MUL, S_ZC_ADD, S_P_MUL, S_P_CHK, S_X_DIV,
		S_T_MUL, S_T_REC, S_T_DIV, S_T_END, S_POW, S_POW_ACC,
		S_RV_MUL, S_RV_ST, S_AD_LO, S_AD_SUM, S_Q_CHK, S_Q_DIV,
		S_SE_MUL, S_SUM, S_DONE
	} state_t;

	// Reciprocal floor(2^32 / k) for the series divisors.
	function automatic logic [31:0] recip(input logic [3:0] k);
		logic [31:0] r;
		case (k)
			4'd2: r = 32'd2147483648;
			4'd3: r = 32'd1431655765;
			4'd4: r = 32'd1073741824;
			4'd5: r = 32'd858993459;
			4'd6: r = 32'd715827882;
			4'd7: r = 32'd613566756;
			4'd8: r = 32'd536870912;
			4'd9: r = 32'd477218588;
			4'd10: r = 32'd429496729;
			4'd11: r = 32'd390451572;
			4'd12: r = 32'd357913941;
			4'd13: r = 32'd330382099;
			default: r = 32'hFFFF_FFFF;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// ----- src/one_compartment_infusion_step_top.sv -----
// One word at a time; the next word is taken once the result is registered.
// The datapath uses the one-bit-per-cycle divider and the single shared multiplier.
// Reset clears the stored amount to zero and empties the output register.
`default_nettype none
`include "one_compartment_infusion_step_top_defines.svh"
module one_compartment_infusion_step_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [31:0] interval,
	input wire logic [31:0] dose_rate,
	input wire logic [31:0] volume,
	input wire logic [31:0] clearance,
	output logic out_valid,
	input wire logic out_ready,
	output logic [31:0] amount
);
	ocis_pkg::state_t state_q, state_d;
	ocis_pkg::div_req_t div_req;
	logic div_busy;
	logic [36:0] quot;
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	logic out_load;
	logic out_valid_q;
	logic [31:0] amount_q;
	logic [31:0] stored_q;
	logic [31:0] t_q, rate_q, v_q, c_q;
	logic [31:0] f_q, term_q, num_q, inf_q, res_q;
	logic [4:0] cnt_q;
	logic [3:0] k_q;
	logic [33:0] pos_q, neg_q;
	logic [32:0] e_q;
	logic [63:0] a_q;
	logic [64:0] nh_q;
	logic [32:0] d;
	logic [31:0] qe, qn;
	logic [35:0] rem_t;
	logic [33:0] diff;
	logic [64:0] rnd;
	logic [31:0] carry;
	logic [32:0] sum33;
	logic [48:0] sum49;
	logic div_wait;
	logic pow_acc;

	ocis_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));
	ocis_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .busy(div_busy), .quot(quot));

	always_comb begin
		d = 33'h1_0000_0000 - e_q;
		qe = prod[63:32];
		rem_t = {4'b0, num_q} - 36'(36'(qe) * 36'(k_q));
		qn = qe + 32'(rem_t >= 36'(k_q));
		diff = pos_q - neg_q;
		rnd = {1'b0, prod} + 65'h0_8000_0000;
		carry = e_q[32] ? stored_q : prod[63:32];
		sum33 = {1'b0, inf_q} + {1'b0, carry};
		sum49 = {17'b0, stored_q} + {1'b0, prod[63:16]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ocis_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mul_a = '0;
		mul_b = '0;
		div_req = '0;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ocis_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = (clearance == 32'd0) ? ocis_pkg::S_ZC_MUL : ocis_pkg::S_P_MUL;
				end
			end
			ocis_pkg::S_ZC_MUL: begin
				mul_a = rate_q;
				mul_b = t_q;
				state_d = ocis_pkg::S_ZC_ADD;
			end
			ocis_pkg::S_ZC_ADD: state_d = ocis_pkg::S_DONE;
			ocis_pkg::S_P_MUL: begin
				mul_a = c_q;
				mul_b = t_q;
				state_d = ocis_pkg::S_P_CHK;
			end
			ocis_pkg::S_P_CHK: begin
				if (prod[63:21] >= {11'b0, v_q}) begin
					state_d = ocis_pkg::S_RV_MUL;
				end else begin
					div_req.start = 1'b1;
					div_req.divisor = v_q;
					div_req.hi = prod[52:21];
					div_req.lo = {prod[20:0], 16'b0};
					div_req.steps = ocis_pkg::X_STEPS;
					state_d = ocis_pkg::S_X_DIV;
				end
			end
			ocis_pkg::S_X_DIV: begin
				if (!div_busy) begin
					state_d = ocis_pkg::S_T_MUL;
				end
			end
			ocis_pkg::S_T_MUL: begin
				mul_a = term_q;
				mul_b = f_q;
				state_d = ocis_pkg::S_T_REC;
			end
			ocis_pkg::S_T_REC: begin
				mul_a = prod[63:32];
				mul_b = ocis_pkg::recip(k_q);
				state_d = ocis_pkg::S_T_DIV;
			end
			ocis_pkg::S_T_DIV: begin
				state_d = (k_q == ocis_pkg::TERM_LAST) ? ocis_pkg::S_T_END : ocis_pkg::S_T_MUL;
			end
			ocis_pkg::S_T_END: state_d = ocis_pkg::S_POW;
			ocis_pkg::S_POW: begin
				if (cnt_q == 5'd0) begin
					state_d = ocis_pkg::S_RV_MUL;
				end else if (!e_q[32]) begin
					mul_a = e_q[31:0];
					mul_b = ocis_pkg::EXP_NEG_ONE;
					state_d = ocis_pkg::S_POW_ACC;
				end
			end
			ocis_pkg::S_POW_ACC: state_d = ocis_pkg::S_POW;
			ocis_pkg::S_RV_MUL: begin
				mul_a = rate_q;
				mul_b = v_q;
				state_d = ocis_pkg::S_RV_ST;
			end
			ocis_pkg::S_RV_ST: begin
				if (d[32]) begin
					state_d = ocis_pkg::S_Q_CHK;
				end else begin
					mul_a = prod[63:32];
					mul_b = d[31:0];
					state_d = ocis_pkg::S_AD_LO;
				end
			end
			ocis_pkg::S_AD_LO: begin
				mul_a = a_q[31:0];
				mul_b = d[31:0];
				state_d = ocis_pkg::S_AD_SUM;
			end
			ocis_pkg::S_AD_SUM: state_d = ocis_pkg::S_Q_CHK;
			ocis_pkg::S_Q_CHK: begin
				if (nh_q[64:32] >= {1'b0, c_q}) begin
					state_d = ocis_pkg::S_SE_MUL;
				end else begin
					div_req.start = 1'b1;
					div_req.divisor = c_q;
					div_req.hi = nh_q[63:32];
					div_req.lo = {nh_q[31:0], 5'b0};
					div_req.steps = ocis_pkg::Q_STEPS;
					state_d = ocis_pkg::S_Q_DIV;
				end
			end
			ocis_pkg::S_Q_DIV: begin
				if (!div_busy) begin
					state_d = ocis_pkg::S_SE_MUL;
				end
			end
			ocis_pkg::S_SE_MUL: begin
				mul_a = stored_q;
				mul_b = e_q[31:0];
				state_d = ocis_pkg::S_SUM;
			end
			ocis_pkg::S_SUM: state_d = ocis_pkg::S_DONE;
			ocis_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d = ocis_pkg::S_IDLE;
				end
			end
			default: state_d = ocis_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				stored_q <= res_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			amount_q <= res_q;
		end
		case (state_q)
			ocis_pkg::S_IDLE: begin
				if (in_valid) begin
					t_q <= interval;
					rate_q <= dose_rate;
					v_q <= (volume == 32'd0) ? 32'd1 : volume;
					c_q <= clearance;
				end
			end
			ocis_pkg::S_ZC_ADD: begin
				res_q <= (|sum49[48:32]) ? ocis_pkg::AMOUNT_MAX : sum49[31:0];
			end
			ocis_pkg::S_P_CHK: begin
				e_q <= '0;
			end
			ocis_pkg::S_X_DIV: begin
				if (!div_busy) begin
					f_q <= quot[31:0];
					term_q <= quot[31:0];
					cnt_q <= quot[36:32];
					neg_q <= {2'b0, quot[31:0]};
					pos_q <= ocis_pkg::ONE_Q32;
					k_q <= ocis_pkg::TERM_FIRST;
				end
			end
			ocis_pkg::S_T_REC: begin
				num_q <= prod[63:32];
			end
			ocis_pkg::S_T_DIV: begin
				term_q <= qn;
				if (k_q[0]) begin
					neg_q <= neg_q + {2'b0, qn};
				end else begin
					pos_q <= pos_q + {2'b0, qn};
				end
				k_q <= k_q + 4'd1;
			end
			ocis_pkg::S_T_END: begin
				if (neg_q >= pos_q) begin
					e_q <= '0;
				end else if (diff > ocis_pkg::ONE_Q32) begin
					e_q <= 33'h1_0000_0000;
				end else begin
					e_q <= diff[32:0];
				end
			end
			ocis_pkg::S_POW: begin
				if (cnt_q != 5'd0 && e_q[32]) begin
					e_q <= {1'b0, ocis_pkg::EXP_NEG_ONE};
					cnt_q <= cnt_q - 5'd1;
				end
			end
			ocis_pkg::S_POW_ACC: begin
				e_q <= rnd[64:32];
				cnt_q <= cnt_q - 5'd1;
			end
			ocis_pkg::S_RV_ST: begin
				a_q <= prod;
				if (d[32]) begin
					nh_q <= {1'b0, prod};
				end
			end
			ocis_pkg::S_AD_LO: begin
				nh_q <= {1'b0, prod};
			end
			ocis_pkg::S_AD_SUM: begin
				nh_q <= nh_q + {33'b0, prod[63:32]};
			end
			ocis_pkg::S_Q_CHK: begin
				if (nh_q[64:32] >= {1'b0, c_q}) begin
					inf_q <= ocis_pkg::AMOUNT_MAX;
				end
			end
			ocis_pkg::S_Q_DIV: begin
				if (!div_busy) begin
					inf_q <= quot[31:0];
				end
			end
			ocis_pkg::S_SUM: begin
				res_q <= sum33[32] ? ocis_pkg::AMOUNT_MAX : sum33[31:0];
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign amount = amount_q;
	assign div_wait = (state_q == ocis_pkg::S_X_DIV) || (state_q == ocis_pkg::S_Q_DIV);
	assign pow_acc = (state_q == ocis_pkg::S_POW_ACC);

	`OCIS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "Word accepted while busy.")
	`OCIS_ASSERT(a_div_in_wait_state, !div_busy || div_wait, "Divider busy outside a divide wait.")
	`OCIS_ASSERT_NEXT(a_stored_holds, !out_load, $stable(stored_q), "Stored amount changed.")
	`OCIS_ASSERT_NEXT(a_pow_count, pow_acc, cnt_q == $past(cnt_q) - 5'd1, "Power count did not step.")
endmodule
`default_nettype wire

// ----- src/ocis_mul.sv -----
// Shared 32 by 32 bit multiplier with a registered product.
`default_nettype none
module ocis_mul (
	input wire logic clk,
	input wire logic [31:0] a,
	input wire logic [31:0] b,
	output logic [63:0] prod
);
	logic [63:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= 64'(a) * 64'(b);
	end

	assign prod = prod_q;
endmodule
`default_nettype wire

// ----- src/ocis_div.sv -----
// Restoring divider that retires one quotient bit per cycle.
`default_nettype none
module ocis_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire ocis_pkg::div_req_t req,
	output logic busy,
	output logic [36:0] quot
);
	logic busy_q;
	logic [5:0] cnt_q;
	logic [31:0] rem_q;
	logic [31:0] div_q;
	logic [36:0] lo_q;
	logic [36:0] quot_q;
	logic [32:0] trial;
	logic ge;
	logic [31:0] rem_d;

	always_comb begin
		trial = {rem_q, lo_q[36]};
		ge = trial >= {1'b0, div_q};
		rem_d = ge ? 32'(trial - {1'b0, div_q}) : trial[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q <= req.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.hi;
			lo_q <= req.lo;
			div_q <= req.divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_d;
			lo_q <= {lo_q[35:0], 1'b0};
			quot_q <= {quot_q[35:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;
endmodule
`default_nettype wire

// ----- sim/tb_one_compartment_infusion_step_top.sv -----
// Self-checking testbench for the one-compartment infusion step, with a scoreboard class.
`timescale 1ns / 100ps
`default_nettype none
module tb_one_compartment_infusion_step_top;
	localparam int TERMS = 13;
	localparam logic [63:0] Q32_ONE = 64'h1_0000_0000;
	localparam logic [63:0] E_INV = 64'd1580030169;
	localparam logic [63:0] SAT = 64'hFFFF_FFFF;

	class amount_scoreboard;
		logic [31:0] held_amount;
		logic [31:0] expected_amounts[$];
		int errors;
		int checked;

		function new();
			held_amount = '0;
			errors = 0;
			checked = 0;
		endfunction

		function logic [63:0] series_decay(logic [63:0] f);
			logic [63:0] term, pos, neg;
			term = Q32_ONE;
			pos = Q32_ONE;
			neg = 0;
			for (int k = 1; k <= TERMS; k++) begin
				term = ((term * f) >> 32) / k;
				if (k % 2 == 1)
					neg += term;
				else
					pos += term;
			end
			if (neg >= pos)
				return 0;
			pos -= neg;
			return (pos > Q32_ONE) ? Q32_ONE : pos;
		endfunction

		function logic [63:0] decay(logic [63:0] c, logic [63:0] t, logic [63:0] v);
			logic [63:0] p, q, r, x, e, n;
			p = c * t;
			q = p / v;
			r = p % v;
			if (q >= (64'd1 << 21))
				return 0;
			x = (q << 16) + ((r << 16) / v);
			n = x >> 32;
			e = series_decay(x & SAT);
			for (int i = 0; i < n; i++)
				e = (e * E_INV + (64'd1 << 31)) >> 32;
			return e;
		endfunction

		function void note_word(logic [31:0] t32, logic [31:0] r32, logic [31:0] v32,
				logic [31:0] c32);
			logic [63:0] t, rate, v, c, s, res, e, d, a, q1, r1, qh, ql, inf, carry, low;
			t = t32;
			rate = r32;
			v = (v32 == 0) ? 64'd1 : v32;
			c = c32;
			s = held_amount;
			if (c == 0) begin
				res = s + ((rate * t) >> 16);
				if (res > SAT)
					res = SAT;
			end else begin
				e = decay(c, t, v);
				d = Q32_ONE - e;
				a = rate * v;
				q1 = a / c;
				r1 = a % c;
				qh = q1 >> 32;
				ql = q1 & SAT;
				carry = (s * e) >> 32;
				inf = qh * d;
				if (inf > SAT) begin
					inf = SAT;
				end else begin
					low = ql * d + (r1 * d) / c;
					inf += low >> 32;
					if (inf > SAT)
						inf = SAT;
				end
				res = inf + carry;
				if (res > SAT)
					res = SAT;
			end
			held_amount = res[31:0];
			expected_amounts.push_back(res[31:0]);
		endfunction

		function void check_word(logic [31:0] got);
			logic [31:0] want;
			if (expected_amounts.size() == 0) begin
				$error("amount: unexpected word %h", got);
				errors++;
				return;
			end
			want = expected_amounts.pop_front();
			checked++;
			if (got !== want) begin
				$error("amount: expected %h, actual %h", want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [31:0] interval = 0, dose_rate = 0, volume = 0, clearance = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [31:0] amount;
	amount_scoreboard board = new();
	int burst_left = 0;
	int zero_clear_words = 0;

	one_compartment_infusion_step_top dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.interval(interval), .dose_rate(dose_rate), .volume(volume),
		.clearance(clearance), .out_valid(out_valid), .out_ready(out_ready),
		.amount(amount)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (out_valid && out_ready)
			board.check_word(amount);
		case ($urandom_range(0, 3))
			0: out_ready <= ($urandom_range(0, 4) != 0);
			1: out_ready <= 1'b1;
			default: out_ready <= ($urandom_range(0, 1) == 1);
		endcase
	end

	task automatic send_dose(logic [31:0] t, logic [31:0] r, logic [31:0] v, logic [31:0] c);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 8);
		end
		burst_left--;
		in_valid <= 1'b1;
		interval <= t;
		dose_rate <= r;
		volume <= v;
		clearance <= c;
		do
			@(posedge clk);
		while (!in_ready);
		board.note_word(t, r, v, c);
		if (c == 0)
			zero_clear_words++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (board.expected_amounts.size() != 0);
	endtask

	function automatic logic [31:0] pick_q16();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $urandom_range(0, 32'h0000_FFFF);
			2: return $urandom_range(32'h0000_8000, 32'h0010_0000);
			3: return 32'h0001_0000 << $urandom_range(0, 12);
			4: return 32'hFFFF_FFFF - $urandom_range(0, 255);
			default: return $urandom_range(32'h0000_1000, 32'h0100_0000);
		endcase
	endfunction

	initial begin
		logic [31:0] c;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_dose(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000);
		send_dose(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0000);
		send_dose(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_4000);
		send_dose(32'h0000_0000, 32'h0005_0000, 32'h0002_0000, 32'h0001_0000);
		send_dose(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
		send_dose(32'h0000_0001, 32'h0003_0000, 32'h0000_0000, 32'h0001_0000);
		send_dose(32'h0040_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
		send_dose(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_dose(32'h0001_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
		send_dose(32'h001F_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000);
		send_dose(32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001);
		send_dose(32'h0002_8000, 32'h0010_0000, 32'h000A_0000, 32'h0003_0000);
		drain();
		for (int i = 0; i < 440; i++) begin
			c = ($urandom_range(0, 7) == 0) ? 32'h0 : pick_q16();
			send_dose(pick_q16(), pick_q16(), pick_q16(), c);
			if (i == 200)
				drain();
		end
		drain();
		repeat (300) @(posedge clk);
		$display("Checked %0d amounts, %0d with zero clearance, random bursts and stalls.",
			board.checked, zero_clear_words);
		if (board.errors == 0 && board.expected_amounts.size() == 0)
			$display("tb_one_compartment_infusion_step_top OK");
		else
			$display("tb_one_compartment_infusion_step_top NOT OK");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb_one_compartment_infusion_step_top NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
